/* rtl/tlc_pkg.sv */
// Shared types and codes for the track label cache.
package tlc_pkg;

  localparam logic [1:0] REQ_CLASSIFIED = 2'd0;
  localparam logic [1:0] REQ_TRACKED    = 2'd1;
  localparam logic [1:0] REQ_END_FRAME  = 2'd2;
  localparam logic [1:0] REQ_NONE       = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  localparam int unsigned LIMIT_W = 14;
  localparam int unsigned EVICT_W = 7;
  localparam logic [EVICT_W-1:0] EVICT_MAX = '1;
  localparam logic signed [15:0] AGE_FRESH = 16'sd1;

  typedef enum logic {
    AGE_INC,
    AGE_DEC
  } tlc_age_dir_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [63:0]        track_id;
    logic signed [15:0] class_id_in;
    logic [15:0]        label_index_in;
    logic [15:0]        confidence_in;
  } tlc_req_t;

  typedef struct packed {
    logic [63:0]          track_id_out;
    logic signed [15:0]   class_id_out;
    logic [15:0]          label_index_out;
    logic [15:0]          confidence_out;
    logic [1:0]           status;
    logic [EVICT_W-1:0]   evicted_count;
  } tlc_rsp_t;

  typedef struct packed {
    logic [63:0]        id;
    logic signed [15:0] cls;
    logic [15:0]        label;
    logic [15:0]        conf;
    logic signed [15:0] age;
  } tlc_row_t;

  typedef struct packed {
    logic signed [15:0] age;
    logic               evict;
  } tlc_age_res_t;

endpackage

/* rtl/tlc_table.sv */
// Entry store: one write port, one registered read port.
module tlc_table #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(ENTRIES)-1:0] wr_addr,
  input  tlc_pkg::tlc_row_t          wr_row,
  input  logic                       rd_en,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr,
  output tlc_pkg::tlc_row_t          rd_row
);

  tlc_pkg::tlc_row_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row <= mem[rd_addr];
    end
  end

endmodule

/* rtl/tlc_age_unit.sv */
// Shared age step: saturating raise or decay, plus the eviction compare.
module tlc_age_unit (
  input  logic signed [15:0]               age,
  input  tlc_pkg::tlc_age_dir_t            dir,
  input  logic [tlc_pkg::LIMIT_W-1:0]      lost_limit,
  output tlc_pkg::tlc_age_res_t            res
);

  logic signed [16:0] sum;
  logic signed [16:0] neg_limit;
  logic signed [15:0] age_new;

  always_comb begin
    sum       = 17'sd0;
    age_new   = age;
    neg_limit = -$signed({3'b000, lost_limit});
    unique case (dir)
      tlc_pkg::AGE_INC: begin
        sum = {age[15], age} + 17'sd1;
        if (sum > 17'sd32767) begin
          age_new = 16'sd32767;
        end else if (sum < 17'sd1) begin
          age_new = 16'sd1;
        end else begin
          age_new = sum[15:0];
        end
      end
      tlc_pkg::AGE_DEC: begin
        sum = {age[15], age} - 17'sd1;
        if (sum > -17'sd1) begin
          age_new = -16'sd1;
        end else if (sum < -17'sd32768) begin
          age_new = -16'sd32768;
        end else begin
          age_new = sum[15:0];
        end
      end
      default: begin
        age_new = age;
      end
    endcase
    res.age   = age_new;
    res.evict = ($signed({age_new[15], age_new}) < neg_limit);
  end

endmodule

/* rtl/track_label_cache.sv */
// Track label cache top level: serial scan sequencer over the entry store.
// A word is taken only while idle and is worked through before the next one is taken: the
//   single read port is walked once per word; busy drops in the cycle the result is shown.
// Reset (synchronous, active high) clears all valid and seen bits and loads lost_limit
//   with 30; the entry store is not swept, so the block is ready the cycle after reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
module track_label_cache #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  tlc_pkg::tlc_req_t               item,
  output logic                            result_valid,
  output tlc_pkg::tlc_rsp_t               result,
  input  logic                            cfg_we,
  input  logic [tlc_pkg::LIMIT_W-1:0]     cfg_data
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_ENTRIES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t state;

  // Request held for the whole scan.
  tlc_pkg::tlc_req_t req;

  // Scan address counter and the compare stage, which works on each address in the cycle
  // after it is issued (the read data of the store is registered).
  logic [CNT_W-1:0] cnt;
  logic             cmp_vld;
  logic [IDX_W-1:0] cmp_idx;

  // Scan findings.
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  tlc_pkg::tlc_row_t hit_row;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic [tlc_pkg::EVICT_W-1:0] evicted;

  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic [TABLE_ENTRIES-1:0] entry_seen;
  logic [tlc_pkg::LIMIT_W-1:0] lost_limit;

  // Store ports.
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  tlc_pkg::tlc_row_t wr_row;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  tlc_pkg::tlc_row_t rd_row;

  // Age unit, shared by the sweep (decay) and the tracked update (raise).
  logic signed [15:0]    age_in;
  tlc_pkg::tlc_age_dir_t age_dir;
  tlc_pkg::tlc_age_res_t age_res;

  logic              scan_issue;
  logic              cmp_match;
  logic              sweep_hit;
  tlc_pkg::tlc_rsp_t rsp_next;

  assign busy = (state != ST_IDLE);

  tlc_table #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_row  (wr_row),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_row  (rd_row)
  );

  tlc_age_unit u_age (
    .age        (age_in),
    .dir        (age_dir),
    .lost_limit (lost_limit),
    .res        (age_res)
  );

  // Issue one read per cycle until the whole table has been addressed.
  assign scan_issue = (state == ST_SCAN) && (cnt != CNT_END);
  assign rd_en      = scan_issue;
  assign rd_addr    = cnt[IDX_W-1:0];

  // Compare stage: id match for lookups, stale entry for the sweep.
  assign cmp_match = cmp_vld && entry_valid[cmp_idx] && (rd_row.id == req.track_id);
  assign sweep_hit = cmp_vld && (req.req_type == tlc_pkg::REQ_END_FRAME) &&
                     entry_valid[cmp_idx] && !entry_seen[cmp_idx];

  always_comb begin
    age_dir = (req.req_type == tlc_pkg::REQ_END_FRAME) ? tlc_pkg::AGE_DEC : tlc_pkg::AGE_INC;
    age_in  = (state == ST_FINISH) ? hit_row.age : rd_row.age;
  end

  // Store writes: age decay during the sweep, entry update at the end of a lookup.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cmp_idx;
    wr_row  = rd_row;
    if (state == ST_SCAN) begin
      wr_en      = sweep_hit;
      wr_addr    = cmp_idx;
      wr_row     = rd_row;
      wr_row.age = age_res.age;
    end else if (state == ST_FINISH) begin
      if (req.req_type == tlc_pkg::REQ_CLASSIFIED) begin
        wr_en        = hit || free_found;
        wr_addr      = hit ? hit_idx : free_idx;
        wr_row.id    = req.track_id;
        wr_row.cls   = req.class_id_in;
        wr_row.label = req.label_index_in;
        wr_row.conf  = req.confidence_in;
        wr_row.age   = tlc_pkg::AGE_FRESH;
      end else if (req.req_type == tlc_pkg::REQ_TRACKED) begin
        wr_en      = hit;
        wr_addr    = hit_idx;
        wr_row     = hit_row;
        wr_row.age = age_res.age;
      end
    end
  end

  // Result word formed in the finish cycle.
  always_comb begin
    rsp_next = '0;
    unique case (req.req_type)
      tlc_pkg::REQ_CLASSIFIED: begin
        rsp_next.track_id_out    = req.track_id;
        rsp_next.class_id_out    = req.class_id_in;
        rsp_next.label_index_out = req.label_index_in;
        rsp_next.confidence_out  = req.confidence_in;
        rsp_next.status          = (hit || free_found) ? tlc_pkg::STATUS_OK
                                                       : tlc_pkg::STATUS_FULL;
      end
      tlc_pkg::REQ_TRACKED: begin
        rsp_next.track_id_out = req.track_id;
        if (hit) begin
          rsp_next.class_id_out    = hit_row.cls;
          rsp_next.label_index_out = hit_row.label;
          rsp_next.confidence_out  = hit_row.conf;
          rsp_next.status          = tlc_pkg::STATUS_OK;
        end else begin
          // Missing id: unknown class, empty label, zero confidence.
          rsp_next.class_id_out = '1;
          rsp_next.status       = tlc_pkg::STATUS_NOT_FOUND;
        end
      end
      tlc_pkg::REQ_END_FRAME: begin
        rsp_next.evicted_count = evicted;
      end
      default: begin
        rsp_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lost_limit <= tlc_pkg::LIMIT_W'(30);
    end else if (cfg_we) begin
      lost_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      cmp_vld      <= 1'b0;
      entry_valid  <= '0;
      entry_seen   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          result_valid <= 1'b0;
          if (start) begin
            req        <= item;
            cnt        <= '0;
            cmp_vld    <= 1'b0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            evicted    <= '0;
            // Drop the unused request code without a result.
            if (item.req_type != tlc_pkg::REQ_NONE) begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          result_valid <= 1'b0;
          // Advance the address and carry it into the compare stage.
          cmp_vld <= scan_issue;
          cmp_idx <= cnt[IDX_W-1:0];
          if (scan_issue) begin
            cnt <= cnt + CNT_W'(1);
            if (!free_found && !entry_valid[cnt[IDX_W-1:0]]) begin
              free_found <= 1'b1;
              free_idx   <= cnt[IDX_W-1:0];
            end
          end
          if (req.req_type == tlc_pkg::REQ_END_FRAME) begin
            if (cmp_vld) begin
              entry_seen[cmp_idx] <= 1'b0;
            end
            if (sweep_hit && age_res.evict) begin
              entry_valid[cmp_idx] <= 1'b0;
              if (evicted != tlc_pkg::EVICT_MAX) begin
                evicted <= evicted + tlc_pkg::EVICT_W'(1);
              end
            end
          end else if (cmp_match && !hit) begin
            hit     <= 1'b1;
            hit_idx <= cmp_idx;
            hit_row <= rd_row;
          end
          // The last compare is done in the cycle the counter sits at the end.
          if (!scan_issue) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (wr_en) begin
            entry_valid[wr_addr] <= 1'b1;
            entry_seen[wr_addr]  <= 1'b1;
          end
          result       <= rsp_next;
          result_valid <= 1'b1;
          state        <= ST_IDLE;
        end
        default: begin
          result_valid <= 1'b0;
          state        <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/tlc_checker.sv */
// Port-level checks for the track label cache, bound to the top level.
module tlc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input tlc_pkg::tlc_req_t           item,
  input logic                        result_valid,
  input tlc_pkg::tlc_rsp_t           result
);

  a_result_when_free: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result shown while busy");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (item.req_type != tlc_pkg::REQ_NONE)) |=> busy)
    else $error("accepted word did not start a scan");

  a_unused_code_dropped: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (item.req_type == tlc_pkg::REQ_NONE)) |=> (!busy && !result_valid))
    else $error("unused request code was not dropped");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe longer than one cycle");

  a_not_found_fields: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status == tlc_pkg::STATUS_NOT_FOUND)) |->
      ((result.class_id_out == -16'sd1) && (result.label_index_out == 16'd0) &&
       (result.confidence_out == 16'd0) && (result.evicted_count == '0)))
    else $error("not-found result carries class data");

endmodule

bind track_label_cache tlc_checker u_tlc_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .item         (item),
  .result_valid (result_valid),
  .result       (result)
);
